FILE: rtl/ufc_pkg.sv
`default_nettype none

package ufc_pkg;

  localparam int unsigned NUM_SPEC = 6;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_SCHEME  = 3'd1,
    PH_COLON   = 3'd2,
    PH_SLASH1  = 3'd3,
    PH_AUTH    = 3'd4,
    PH_DECIDED = 3'd5
  } parse_phase_t;

  typedef enum logic [1:0] {
    FR_RELATIVE = 2'd0,
    FR_IPV6     = 2'd1,
    FR_EMPTY    = 2'd2,
    FR_INVALID  = 2'd3
  } fault_reason_t;

  typedef struct packed {
    parse_phase_t          phase;
    logic [2:0]            scheme_length;
    logic [NUM_SPEC-1:0]   special_match_bits;
    logic                  bracket_opened;
    logic                  bracket_closed;
    logic                  authority_nonempty;
    fault_reason_t         held_verdict;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase:              PH_START,
    scheme_length:      3'd0,
    special_match_bits: {NUM_SPEC{1'b1}},
    bracket_opened:     1'b0,
    bracket_closed:     1'b0,
    authority_nonempty: 1'b0,
    held_verdict:       FR_RELATIVE
  };

  // Special scheme names, lower case, padded with zeros to eight bytes
  localparam logic [7:0] SPEC_NAME [NUM_SPEC][8] = '{
    '{8'h68, 8'h74, 8'h74, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},  // http
    '{8'h68, 8'h74, 8'h74, 8'h70, 8'h73, 8'h00, 8'h00, 8'h00},  // https
    '{8'h77, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // ws
    '{8'h77, 8'h73, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // wss
    '{8'h66, 8'h74, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // ftp
    '{8'h66, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00}   // file
  };

  localparam logic [2:0] SPEC_LEN [NUM_SPEC] = '{
    3'd4, 3'd5, 3'd2, 3'd3, 3'd3, 3'd4
  };

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;

endpackage

`default_nettype wire

FILE: rtl/ufc_parser.sv
`default_nettype none

module ufc_parser
  import ufc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    text_byte,
  input  wire logic          byte_present,
  input  wire logic          final_item,
  output fault_reason_t      verdict
);

  parse_state_t state;
  parse_state_t state_next;
  parse_state_t after_byte;

  logic [7:0] low;
  logic       is_alpha;
  logic       is_scheme_char;
  logic       auth_end;
  logic       no_auth_special;
  fault_reason_t auth_verdict;

  assign is_alpha = ((text_byte >= 8'h61) && (text_byte <= 8'h7A)) ||
                    ((text_byte >= 8'h41) && (text_byte <= 8'h5A));
  assign is_scheme_char = is_alpha || ((text_byte >= 8'h30) && (text_byte <= 8'h39)) ||
                          (text_byte == CH_PLUS) || (text_byte == CH_MINUS) ||
                          (text_byte == CH_DOT);
  assign low = ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ?
               (text_byte | 8'h20) : text_byte;
  assign auth_end = (text_byte == CH_SLASH) || (text_byte == CH_QUEST) ||
                    (text_byte == CH_HASH);

  assign no_auth_special = |state.special_match_bits;
  assign auth_verdict = (state.bracket_opened && !state.bracket_closed) ? FR_IPV6 :
                        (!state.authority_nonempty) ? FR_EMPTY : FR_INVALID;

  // Next state: apply the byte, then clear at the end of the text
  always_comb begin
    after_byte = state;
    if (byte_present) begin
      unique case (state.phase)
        PH_START: begin
          if (is_alpha) begin
            for (int i = 0; i < NUM_SPEC; i++) begin
              if ((state.scheme_length >= SPEC_LEN[i]) ||
                  (SPEC_NAME[i][state.scheme_length] != low)) begin
                after_byte.special_match_bits[i] = 1'b0;
              end
            end
            if (state.scheme_length != 3'd7) begin
              after_byte.scheme_length = state.scheme_length + 3'd1;
            end
            after_byte.phase = PH_SCHEME;
          end else begin
            after_byte.held_verdict = FR_RELATIVE;
            after_byte.phase = PH_DECIDED;
          end
        end
        PH_SCHEME: begin
          if (text_byte == CH_COLON) begin
            for (int i = 0; i < NUM_SPEC; i++) begin
              if (SPEC_LEN[i] != state.scheme_length) begin
                after_byte.special_match_bits[i] = 1'b0;
              end
            end
            after_byte.phase = PH_COLON;
          end else if (is_scheme_char) begin
            for (int i = 0; i < NUM_SPEC; i++) begin
              if ((state.scheme_length >= SPEC_LEN[i]) ||
                  (SPEC_NAME[i][state.scheme_length] != low)) begin
                after_byte.special_match_bits[i] = 1'b0;
              end
            end
            if (state.scheme_length != 3'd7) begin
              after_byte.scheme_length = state.scheme_length + 3'd1;
            end
          end else begin
            after_byte.held_verdict = FR_RELATIVE;
            after_byte.phase = PH_DECIDED;
          end
        end
        PH_COLON, PH_SLASH1: begin
          if (text_byte == CH_SLASH) begin
            after_byte.phase = (state.phase == PH_COLON) ? PH_SLASH1 : PH_AUTH;
          end else begin
            after_byte.held_verdict = no_auth_special ? FR_EMPTY : FR_INVALID;
            after_byte.phase = PH_DECIDED;
          end
        end
        PH_AUTH: begin
          if (auth_end) begin
            after_byte.held_verdict = auth_verdict;
            after_byte.phase = PH_DECIDED;
          end else begin
            if (text_byte == CH_LBRACK) after_byte.bracket_opened = 1'b1;
            if (text_byte == CH_RBRACK) after_byte.bracket_closed = 1'b1;
            after_byte.authority_nonempty = 1'b1;
          end
        end
        default: begin
          // decided: drop the byte
        end
      endcase
    end
    state_next = final_item ? PARSE_CLEAR : after_byte;
  end

  // Verdict on the state that includes this transaction's byte
  always_comb begin
    unique case (after_byte.phase)
      PH_START, PH_SCHEME: verdict = FR_RELATIVE;
      PH_COLON, PH_SLASH1: begin
        verdict = (|after_byte.special_match_bits) ? FR_EMPTY : FR_INVALID;
      end
      PH_AUTH: begin
        verdict = (after_byte.bracket_opened && !after_byte.bracket_closed) ? FR_IPV6 :
                  (!after_byte.authority_nonempty) ? FR_EMPTY : FR_INVALID;
      end
      default: verdict = after_byte.held_verdict;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PARSE_CLEAR;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/uri_fault_classifier_top.sv
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_ready     text_byte[7:0], byte_present, final_item
// output    out_valid / out_ready   fault_reason[1:0]
//
// One transaction per cycle sustained unless a final one waits on the result register;
// a byte goes through an input register, then the parser updates its state and the
// result register at the same edge, so results pass through both registers.
// A final transaction waits in the input register only while the result
// register is full and not being taken; non-final bytes never wait.
// Synchronous reset returns the parser to the start of text and empties both registers.

module uri_fault_classifier_top
  import ufc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] text_byte,
  input  wire logic       byte_present,
  input  wire logic       final_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      fault_reason
);

  logic          held_valid;
  logic [7:0]    held_byte;
  logic          held_present;
  logic          held_final;
  logic          advance;
  fault_reason_t verdict;

  assign advance  = held_valid && (!held_final || !out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte    <= text_byte;
      held_present <= byte_present;
      held_final   <= final_item;
    end
  end

  ufc_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .text_byte    (held_byte),
    .byte_present (held_present),
    .final_item   (held_final),
    .verdict      (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && held_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_final) begin
      fault_reason <= verdict;
    end
  end

endmodule

`default_nettype wire

FILE: sim/uri_fault_classifier_top_test.sv
`timescale 1ns / 1ps

module uri_fault_classifier_top_test;
  import ufc_pkg::*;

  localparam int unsigned ITEM_TARGET  = 800;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 300;

  // Directed texts, right-justified in txt; want is used only where typed is set
  typedef struct packed {
    logic [2:0]    n;
    logic [47:0]   txt;
    logic          end_only;
    logic          lead_gap;
    logic          typed;
    fault_reason_t want;
  } text_row_t;

  localparam text_row_t DIRECTED_TEXTS [8] = '{
    '{3'd0, 48'h0,            1'b1, 1'b1, 1'b1, FR_RELATIVE},  // empty text
    '{3'd1, 48'h00,           1'b0, 1'b0, 1'b1, FR_RELATIVE},  // bad first byte
    '{3'd4, "WS:/",           1'b0, 1'b0, 1'b1, FR_EMPTY},     // special, cut at slash
    '{3'd2, "q:",             1'b1, 1'b0, 1'b1, FR_INVALID},   // plain, cut at colon
    '{3'd5, "a://[",          1'b0, 1'b0, 1'b1, FR_IPV6},
    '{3'd4, "a://",           1'b1, 1'b0, 1'b1, FR_EMPTY},
    '{3'd5, {"a://", 8'hFF},  1'b0, 1'b0, 1'b1, FR_INVALID},   // non-ASCII host byte
    '{3'd3, "a:x",            1'b0, 1'b0, 1'b0, FR_RELATIVE}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] text_byte = 8'h00;
  logic       byte_present = 1'b0;
  logic       final_item = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] fault_reason;

  uri_fault_classifier_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .byte_present (byte_present),
    .final_item   (final_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .fault_reason (fault_reason)
  );

  fault_reason_t pending_reasons [$];
  fault_reason_t oldest_reason;
  logic [7:0]    text_bytes [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   tx_idle_pct = 20;
  int unsigned   rx_idle_pct = 20;
  bit            long_hold_req = 1'b0;
  bit            offering = 1'b0;

  // Parser state of the predictor
  string         special_scheme [6] = '{"http", "https", "ws", "wss", "ftp", "file"};
  parse_phase_t  ph;
  logic [2:0]    scheme_len;
  logic [5:0]    special_live;
  logic          saw_lbrack;
  logic          saw_rbrack;
  logic          host_seen;
  fault_reason_t early_reason;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_scheme_byte(input logic [7:0] c);
    return is_letter(c) || (c >= "0" && c <= "9") ||
           c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
  endfunction

  function automatic fault_reason_t reason_without_host();
    return (special_live != 6'd0) ? FR_EMPTY : FR_INVALID;
  endfunction

  function automatic fault_reason_t reason_in_host();
    if (saw_lbrack && !saw_rbrack) return FR_IPV6;
    if (!host_seen) return FR_EMPTY;
    return FR_INVALID;
  endfunction

  task automatic clear_parse();
    ph = PH_START;
    scheme_len = 3'd0;
    special_live = 6'h3F;
    saw_lbrack = 1'b0;
    saw_rbrack = 1'b0;
    host_seen = 1'b0;
    early_reason = FR_RELATIVE;
  endtask

  task automatic settle(input fault_reason_t r);
    early_reason = r;
    ph = PH_DECIDED;
  endtask

  task automatic track_scheme(input logic [7:0] c);
    logic [7:0] folded;
    logic [7:0] name_ch;
    folded = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
    for (int i = 0; i < 6; i++) begin
      if (scheme_len >= special_scheme[i].len()) begin
        special_live[i] = 1'b0;
      end else begin
        name_ch = special_scheme[i][scheme_len];
        if (name_ch != folded) special_live[i] = 1'b0;
      end
    end
    if (scheme_len != 3'd7) scheme_len++;
  endtask

  task automatic classify_item(input logic [7:0] c, input logic p, input logic f,
                               output logic done, output fault_reason_t reason);
    if (p) begin
      case (ph)
        PH_START: begin
          if (is_letter(c)) begin
            track_scheme(c);
            ph = PH_SCHEME;
          end else begin
            settle(FR_RELATIVE);
          end
        end
        PH_SCHEME: begin
          if (c == CH_COLON) begin
            for (int i = 0; i < 6; i++)
              if (special_scheme[i].len() != scheme_len) special_live[i] = 1'b0;
            ph = PH_COLON;
          end else if (is_scheme_byte(c)) begin
            track_scheme(c);
          end else begin
            settle(FR_RELATIVE);
          end
        end
        PH_COLON: begin
          if (c == CH_SLASH) ph = PH_SLASH1;
          else settle(reason_without_host());
        end
        PH_SLASH1: begin
          if (c == CH_SLASH) ph = PH_AUTH;
          else settle(reason_without_host());
        end
        PH_AUTH: begin
          if (c == CH_SLASH || c == CH_QUEST || c == CH_HASH) begin
            settle(reason_in_host());
          end else begin
            if (c == CH_LBRACK) saw_lbrack = 1'b1;
            if (c == CH_RBRACK) saw_rbrack = 1'b1;
            host_seen = 1'b1;
          end
        end
        default: ;
      endcase
    end
    done = f;
    reason = FR_RELATIVE;
    if (f) begin
      case (ph)
        PH_START, PH_SCHEME: reason = FR_RELATIVE;
        PH_COLON, PH_SLASH1: reason = reason_without_host();
        PH_AUTH:             reason = reason_in_host();
        default:             reason = early_reason;
      endcase
      clear_parse();
    end
  endtask

  function automatic int unsigned gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 3);
  endfunction

  function automatic int unsigned idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 25;
      default: return 60;
    endcase
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] any_letter();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(0, 25));
    return $urandom_range(0, 1) ? c - 8'h20 : c;
  endfunction

  function automatic logic [7:0] any_scheme_byte();
    case ($urandom_range(0, 7))
      5, 6:    return 8'("0" + $urandom_range(0, 9));
      7: begin
        case ($urandom_range(0, 2))
          0:       return CH_PLUS;
          1:       return CH_MINUS;
          default: return CH_DOT;
        endcase
      end
      default: return any_letter();
    endcase
  endfunction

  function automatic logic [7:0] any_host_byte();
    case ($urandom_range(0, 7))
      0:       return CH_LBRACK;
      1:       return CH_RBRACK;
      2:       return 8'($urandom_range(128, 255));
      3:       return CH_COLON;
      4:       return any_byte();
      default: return any_scheme_byte();
    endcase
  endfunction

  task automatic add_tail(input int unsigned max_len);
    repeat ($urandom_range(0, max_len)) text_bytes.push_back(any_host_byte());
  endtask

  // Mostly scheme-colon-authority texts with random content, the rest noise
  task automatic build_random_text();
    int unsigned len;
    int unsigned pick;
    string       word;
    logic [7:0]  ch;
    text_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(0, 8)) text_bytes.push_back(any_byte());
      return;
    end
    if (pick < 55) begin
      word = special_scheme[$urandom_range(0, 5)];
      for (int k = 0; k < word.len(); k++) begin
        ch = word[k];
        text_bytes.push_back($urandom_range(0, 1) ? ch - 8'h20 : ch);
      end
      // near misses: clip or stretch the special name
      if ($urandom_range(0, 4) == 0) void'(text_bytes.pop_back());
      else if ($urandom_range(0, 4) == 0) text_bytes.push_back(any_scheme_byte());
    end else begin
      len = $urandom_range(1, 9);
      text_bytes.push_back(any_letter());
      repeat (len - 1) text_bytes.push_back(any_scheme_byte());
    end
    if ($urandom_range(0, 9) == 0)
      text_bytes[$urandom_range(0, text_bytes.size() - 1)] = any_byte();
    if ($urandom_range(0, 19) != 0) text_bytes.push_back(CH_COLON);
    case ($urandom_range(0, 9))
      0: ;
      1: text_bytes.push_back(CH_SLASH);
      2: begin
        text_bytes.push_back(any_host_byte());
        add_tail(4);
      end
      3: begin
        text_bytes.push_back(CH_SLASH);
        text_bytes.push_back(any_host_byte());
        add_tail(4);
      end
      default: begin
        text_bytes.push_back(CH_SLASH);
        text_bytes.push_back(CH_SLASH);
        repeat ($urandom_range(0, 6)) text_bytes.push_back(any_host_byte());
        if ($urandom_range(0, 4) < 3) begin
          case ($urandom_range(0, 2))
            0:       text_bytes.push_back(CH_SLASH);
            1:       text_bytes.push_back(CH_QUEST);
            default: text_bytes.push_back(CH_HASH);
          endcase
          add_tail(4);
        end
      end
    endcase
  endtask

  task automatic stop_offering();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic p, input logic f,
                           input logic typed, input fault_reason_t want);
    logic          done;
    fault_reason_t reason;
    in_valid <= 1'b1;
    offering = 1'b1;
    text_byte <= b;
    byte_present <= p;
    final_item <= f;
    do @(posedge clk); while (!in_ready);
    classify_item(b, p, f, done, reason);
    if (done) pending_reasons.push_back(typed ? want : reason);
    if (p || f) items_sent++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      stop_offering();
      repeat (gap_length()) @(posedge clk);
    end
  endtask

  task automatic send_text(input logic end_only, input logic typed, input fault_reason_t want);
    int last;
    last = text_bytes.size();
    foreach (text_bytes[k]) begin
      // stray transaction with no byte: must change nothing
      if ($urandom_range(0, 19) == 0) send_item(any_byte(), 1'b0, 1'b0, 1'b0, FR_RELATIVE);
      send_item(text_bytes[k], 1'b1, !end_only && k == last - 1, typed, want);
    end
    if (end_only || last == 0) send_item(any_byte(), 1'b0, 1'b1, typed, want);
  endtask

  initial begin
    text_row_t   row;
    int          n_bytes;
    int unsigned texts;
    clear_parse();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_TEXTS[r]) begin
      row = DIRECTED_TEXTS[r];
      n_bytes = row.n;
      if (row.lead_gap) send_item(8'hFF, 1'b0, 1'b0, 1'b0, FR_RELATIVE);
      text_bytes.delete();
      for (int k = 0; k < n_bytes; k++) text_bytes.push_back(row.txt[8*(n_bytes-1-k) +: 8]);
      send_text(row.end_only, row.typed, row.want);
    end

    texts = 0;
    while (items_sent < ITEM_TARGET) begin
      if (texts % 25 == 0) begin
        tx_idle_pct = idle_pct();
        rx_idle_pct = idle_pct();
      end
      // hold the receiver off while input keeps coming
      if (texts == 60) long_hold_req = 1'b1;
      // drain everything before going on
      if (texts % 90 == 45) begin
        stop_offering();
        while (pending_reasons.size() != 0) @(posedge clk);
      end
      build_random_text();
      send_text($urandom_range(0, 3) == 0, 1'b0, FR_RELATIVE);
      texts++;
    end

    stop_offering();
    while (pending_reasons.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("uri_fault_classifier_top regression: pass");
    else
      $display("uri_fault_classifier_top regression: fail");
    $finish;
  end

  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < rx_idle_pct) hold = gap_length();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_reasons.size() == 0) begin
        $error("fault_reason: expected none, got %0d", fault_reason);
        mismatch_count++;
      end else begin
        oldest_reason = pending_reasons.pop_front();
        if (fault_reason !== oldest_reason) begin
          $error("fault_reason: expected %0d, got %0d", oldest_reason, fault_reason);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("uri_fault_classifier_top regression: fail");
      $finish;
    end
  end

endmodule
